// File: rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/rtc_pkg.sv
package rtc_pkg;

   localparam int DEF_MAX_TRIS    = 32768;
   localparam int DEF_COORD_WIDTH = 32;

   localparam int COORD_W  = 32;
   localparam int T_W      = 31;
   localparam int UV_W     = 17;
   localparam int IDX_W    = 15;
   localparam int CFG_W    = 16;
   localparam int FAR_W    = 31;
   localparam int FRAC     = 16;
   localparam int SAT_IN_W = 49;
   localparam int DOT_W    = 50;
   localparam int NUM_W    = 49;
   localparam int QUO_W    = 31;
   localparam int PROD_W   = 64;
   localparam int IDX_CAP_MAX = 32767;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [T_W-1:0]   T_MAX          = {T_W{1'b1}};
   localparam logic [CFG_W-1:0] MIN_DIST_RESET = 16'd7;
   localparam logic [CFG_W-1:0] PAR_EPS_RESET  = 16'd1;

   localparam logic CMD_RAY = 1'b0;
   localparam logic CMD_TRI = 1'b1;

   // register index as decoded from the word address
   localparam logic REG_MIN_DIST = 1'b0;
   localparam logic REG_PAR_EPS  = 1'b1;

   typedef logic [2:0][COORD_W-1:0] vec3_type;
   typedef logic [2:0][NUM_W-1:0]   num3_type;
   typedef logic [2:0][QUO_W-1:0]   quo3_type;

   typedef struct packed {
      logic                    cmd;
      logic signed [COORD_W-1:0] p_x;
      logic signed [COORD_W-1:0] p_y;
      logic signed [COORD_W-1:0] p_z;
      logic signed [COORD_W-1:0] q_x;
      logic signed [COORD_W-1:0] q_y;
      logic signed [COORD_W-1:0] q_z;
      logic signed [COORD_W-1:0] r_x;
      logic signed [COORD_W-1:0] r_y;
      logic signed [COORD_W-1:0] r_z;
      logic [FAR_W-1:0]        far_limit;
   } rtc_req_type;

   typedef struct packed {
      logic             any_hit;
      logic             this_hit;
      logic [T_W-1:0]   closest_t;
      logic [UV_W-1:0]  closest_u;
      logic [UV_W-1:0]  closest_v;
      logic [IDX_W-1:0] closest_index;
   } rtc_rsp_type;

   // classified item: ray (origin, saturated direction) or triangle (v0, edges)
   typedef struct packed {
      logic             is_tri;
      vec3_type         pnt;
      vec3_type         edge1;
      vec3_type         edge2;
      logic [FAR_W-1:0] far;
   } rtc_job_type;

   typedef struct packed {
      logic full;
      logic valid;
   } rtc_q_status_type;

   function automatic int vec_bits(input int cw);
      int r;
      r = cw;
      if (cw > 32) r = 32;
      if (cw < 16) r = 16;
      return r;
   endfunction

   function automatic int tri_cap(input int mt);
      return ((mt - 1) < IDX_CAP_MAX) ? (mt - 1) : IDX_CAP_MAX;
   endfunction

   function automatic logic [COORD_W-1:0] sat_vec(input logic signed [SAT_IN_W-1:0] x,
                                                  input int vb);
      logic signed [SAT_IN_W-1:0] one;
      logic signed [SAT_IN_W-1:0] hi;
      logic signed [SAT_IN_W-1:0] lo;
      logic signed [SAT_IN_W-1:0] r;
      one = SAT_IN_W'(1);
      hi  = (one <<< (vb - 1)) - one;
      lo  = -(one <<< (vb - 1));
      if (x > hi)      r = hi;
      else if (x < lo) r = lo;
      else             r = x;
      return r[COORD_W-1:0];
   endfunction

endpackage

// File: rtl/rtc_front.sv
module rtc_front #(
   parameter int COORD_WIDTH = rtc_pkg::DEF_COORD_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rtc_pkg::rtc_req_type req_data,
   input  logic                 q_full,
   output logic                 push,
   output rtc_pkg::rtc_job_type job
);
   import rtc_pkg::*;

   localparam int VB = vec_bits(COORD_WIDTH);

   logic        valid_ff, valid_in;
   rtc_job_type job_ff, job_in;
   logic        accept;
   vec3_type    p_v, q_v, r_v;

   assign req_stall = valid_ff & q_full;
   assign accept    = req_valid & ~req_stall;
   assign push      = valid_ff & ~q_full;
   assign job       = job_ff;

   assign p_v = {req_data.p_z, req_data.p_y, req_data.p_x};
   assign q_v = {req_data.q_z, req_data.q_y, req_data.q_x};
   assign r_v = {req_data.r_z, req_data.r_y, req_data.r_x};

   // edges for triangles, saturated direction for rays
   always_comb begin
      job_in        = job_ff;
      job_in.is_tri = (req_data.cmd == CMD_TRI);
      job_in.pnt    = p_v;
      job_in.far    = req_data.far_limit;
      for (int i = 0; i < 3; i++) begin
         if (req_data.cmd == CMD_TRI) begin
            job_in.edge1[i] = sat_vec(SAT_IN_W'($signed(q_v[i])) - SAT_IN_W'($signed(p_v[i])), VB);
            job_in.edge2[i] = sat_vec(SAT_IN_W'($signed(r_v[i])) - SAT_IN_W'($signed(p_v[i])), VB);
         end else begin
            job_in.edge1[i] = sat_vec(SAT_IN_W'($signed(q_v[i])), VB);
            job_in.edge2[i] = '0;
         end
      end
   end

   assign valid_in = accept | (valid_ff & ~push);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         job_ff <= job_in;
      end
   end

endmodule

// File: rtl/rtc_queue.sv
module rtc_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  rtc_pkg::rtc_job_type      push_job,
   input  logic                      pop,
   output rtc_pkg::rtc_job_type      head,
   output rtc_pkg::rtc_q_status_type status
);
   import rtc_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   rtc_job_type      entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign status.full  = (cnt_ff == CNT_FULL);
   assign status.valid = (cnt_ff != '0);
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & status.valid;
   assign head         = entry_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == PTR_LAST) ? '0 : wr_ff + 1'b1;
      if (do_pop)  rd_in = (rd_ff == PTR_LAST) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop)      cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_job;
      end
   end

endmodule

// File: rtl/rtc_div.sv
module rtc_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  rtc_pkg::num3_type          num,
   input  logic [rtc_pkg::NUM_W-1:0]  den,
   output rtc_pkg::quo3_type          quo,
   output logic                       done
);
   import rtc_pkg::*;

   localparam int SHIFT = QUO_W - FRAC;
   localparam int CNT_W = $clog2(QUO_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

   num3_type         rem_ff, rem_in;
   quo3_type         low_ff, low_in;
   quo3_type         quo_ff, quo_in;
   logic [NUM_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [NUM_W:0]   sh [3];
   logic             ge [3];

   assign quo  = quo_ff;
   assign done = done_ff;

   // restoring division, three lanes sharing one divisor, one quotient bit a cycle
   always_comb begin
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         sh[i] = {rem_ff[i], low_ff[i][QUO_W-1]};
         ge[i] = (sh[i] >= {1'b0, den_ff});
      end
      if (start) begin
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
         for (int i = 0; i < 3; i++) begin
            rem_in[i] = num[i] >> SHIFT;
            low_in[i] = {num[i][SHIFT-1:0], {FRAC{1'b0}}};
            quo_in[i] = '0;
         end
      end else if (busy_ff) begin
         for (int i = 0; i < 3; i++) begin
            rem_in[i] = ge[i] ? NUM_W'(sh[i] - {1'b0, den_ff}) : sh[i][NUM_W-1:0];
            low_in[i] = {low_ff[i][QUO_W-2:0], 1'b0};
            quo_in[i] = {quo_ff[i][QUO_W-2:0], ge[i]};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

endmodule

// File: rtl/rtc_back.sv
`include "assert_macros.svh"

module rtc_back #(
   parameter int MAX_TRIS    = rtc_pkg::DEF_MAX_TRIS,
   parameter int COORD_WIDTH = rtc_pkg::DEF_COORD_WIDTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rtc_pkg::rtc_job_type      job,
   input  rtc_pkg::rtc_q_status_type q_status,
   output logic                      q_pop,
   input  logic [rtc_pkg::CFG_W-1:0] min_distance,
   input  logic [rtc_pkg::CFG_W-1:0] parallel_epsilon,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rtc_pkg::rtc_rsp_type      rsp_data
);
   import rtc_pkg::*;

   localparam int VB = vec_bits(COORD_WIDTH);
   localparam logic [IDX_W-1:0] CNT_CAP = IDX_W'(tri_cap(MAX_TRIS));
   localparam int TSH = QUO_W - FRAC;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MAC   = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_FINAL = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   localparam logic [4:0] MAC_LAST = 5'd24;

   logic [2:0]  state_ff, state_in;
   logic [4:0]  step_ff, step_in;
   logic [4:0]  acc_step;

   vec3_type org_ff, org_in, dir_ff, dir_in, e1_ff, e1_in, e2_ff, e2_in;
   vec3_type tv_ff, tv_in, pv_ff, pv_in, qv_ff, qv_in;

   logic [T_W-1:0]   best_t_ff, best_t_in;
   logic [UV_W-1:0]  best_u_ff, best_u_in, best_v_ff, best_v_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in, count_ff, count_in;
   logic             found_ff, found_in, this_hit_ff, this_hit_in;
   logic             pass_ff, pass_in, t_over_ff, t_over_in;

   logic signed [SAT_IN_W-1:0] cross_ff, cross_in;
   logic signed [DOT_W-1:0]    det_ff, det_in, un_ff, un_in, vn_ff, vn_in, tn_ff, tn_in;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [COORD_W-1:0]  op_a, op_b;
   logic signed [PROD_W-FRAC-1:0] fp;
   logic signed [SAT_IN_W-1:0] fp_x;
   logic signed [DOT_W-1:0]    fp_d;

   rtc_rsp_type rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        out_free;

   // normalised determinant and numerators
   logic                    det_neg;
   logic signed [DOT_W-1:0] det_abs, un_n, vn_n, tn_n;
   logic signed [DOT_W:0]   uv_sum;
   logic [DOT_W+TSH-1:0]    tn_wide, det_wide;
   logic                    reject, t_over;

   logic             div_start, div_done;
   num3_type         div_num;
   quo3_type         div_quo;
   logic [T_W-1:0]   t_fin;
   logic             hit;

   assign acc_step = step_ff - 5'd1;
   assign fp       = prod_ff[PROD_W-1:FRAC];
   assign fp_x     = SAT_IN_W'(fp);
   assign fp_d     = DOT_W'(fp);
   assign q_pop    = (state_ff == S_IDLE) & q_status.valid;
   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // operand schedule of the shared multiplier
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (step_ff)
         5'd0:  begin op_a = dir_ff[1]; op_b = e2_ff[2]; end
         5'd1:  begin op_a = dir_ff[2]; op_b = e2_ff[1]; end
         5'd2:  begin op_a = dir_ff[2]; op_b = e2_ff[0]; end
         5'd3:  begin op_a = dir_ff[0]; op_b = e2_ff[2]; end
         5'd4:  begin op_a = dir_ff[0]; op_b = e2_ff[1]; end
         5'd5:  begin op_a = dir_ff[1]; op_b = e2_ff[0]; end
         5'd6:  begin op_a = e1_ff[0];  op_b = pv_ff[0]; end
         5'd7:  begin op_a = e1_ff[1];  op_b = pv_ff[1]; end
         5'd8:  begin op_a = e1_ff[2];  op_b = pv_ff[2]; end
         5'd9:  begin op_a = tv_ff[0];  op_b = pv_ff[0]; end
         5'd10: begin op_a = tv_ff[1];  op_b = pv_ff[1]; end
         5'd11: begin op_a = tv_ff[2];  op_b = pv_ff[2]; end
         5'd12: begin op_a = tv_ff[1];  op_b = e1_ff[2]; end
         5'd13: begin op_a = tv_ff[2];  op_b = e1_ff[1]; end
         5'd14: begin op_a = tv_ff[2];  op_b = e1_ff[0]; end
         5'd15: begin op_a = tv_ff[0];  op_b = e1_ff[2]; end
         5'd16: begin op_a = tv_ff[0];  op_b = e1_ff[1]; end
         5'd17: begin op_a = tv_ff[1];  op_b = e1_ff[0]; end
         5'd18: begin op_a = dir_ff[0]; op_b = qv_ff[0]; end
         5'd19: begin op_a = dir_ff[1]; op_b = qv_ff[1]; end
         5'd20: begin op_a = dir_ff[2]; op_b = qv_ff[2]; end
         5'd21: begin op_a = e2_ff[0];  op_b = qv_ff[0]; end
         5'd22: begin op_a = e2_ff[1];  op_b = qv_ff[1]; end
         5'd23: begin op_a = e2_ff[2];  op_b = qv_ff[2]; end
         default: ;
      endcase
   end

   always_comb begin
      det_neg  = det_ff[DOT_W-1];
      det_abs  = det_neg ? -det_ff : det_ff;
      un_n     = det_neg ? -un_ff : un_ff;
      vn_n     = det_neg ? -vn_ff : vn_ff;
      tn_n     = det_neg ? -tn_ff : tn_ff;
      uv_sum   = (DOT_W+1)'(un_n) + (DOT_W+1)'(vn_n);
      tn_wide  = {{TSH{1'b0}}, tn_n};
      det_wide = {det_abs, {TSH{1'b0}}};
      t_over   = (tn_wide >= det_wide);
      reject   = (det_ff == '0) ||
                 (det_abs < $signed(DOT_W'(parallel_epsilon))) ||
                 (un_n < 0) || (un_n > det_abs) ||
                 (vn_n < 0) || (uv_sum > (DOT_W+1)'(det_abs)) ||
                 (tn_n < 0);
      div_num[0] = un_n[NUM_W-1:0];
      div_num[1] = vn_n[NUM_W-1:0];
      div_num[2] = tn_n[NUM_W-1:0];
      t_fin      = t_over_ff ? T_MAX : div_quo[2];
      hit        = pass_ff && (t_fin > T_W'(min_distance)) && (t_fin < best_t_ff);
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      org_in       = org_ff;
      dir_in       = dir_ff;
      e1_in        = e1_ff;
      e2_in        = e2_ff;
      tv_in        = tv_ff;
      pv_in        = pv_ff;
      qv_in        = qv_ff;
      best_t_in    = best_t_ff;
      best_u_in    = best_u_ff;
      best_v_in    = best_v_ff;
      best_idx_in  = best_idx_ff;
      count_in     = count_ff;
      found_in     = found_ff;
      this_hit_in  = this_hit_ff;
      pass_in      = pass_ff;
      t_over_in    = t_over_ff;
      cross_in     = cross_ff;
      det_in       = det_ff;
      un_in        = un_ff;
      vn_in        = vn_ff;
      tn_in        = tn_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      div_start    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_status.valid) begin
               if (job.is_tri) begin
                  e1_in = job.edge1;
                  e2_in = job.edge2;
                  for (int i = 0; i < 3; i++) begin
                     tv_in[i] = sat_vec(SAT_IN_W'($signed(org_ff[i])) -
                                        SAT_IN_W'($signed(job.pnt[i])), VB);
                  end
                  step_in  = '0;
                  state_in = S_MAC;
               end else begin
                  org_in      = job.pnt;
                  dir_in      = job.edge1;
                  best_t_in   = job.far;
                  best_u_in   = '0;
                  best_v_in   = '0;
                  best_idx_in = '0;
                  count_in    = '0;
                  found_in    = 1'b0;
                  this_hit_in = 1'b0;
                  state_in    = S_OUT;
               end
            end
         end
         S_MAC: begin
            step_in = step_ff + 1'b1;
            if (step_ff != '0) begin
               case (acc_step) inside
                  5'd0, 5'd2, 5'd4, 5'd12, 5'd14, 5'd16: cross_in = fp_x;
                  5'd1:  pv_in[0] = sat_vec(cross_ff - fp_x, VB);
                  5'd3:  pv_in[1] = sat_vec(cross_ff - fp_x, VB);
                  5'd5:  pv_in[2] = sat_vec(cross_ff - fp_x, VB);
                  5'd13: qv_in[0] = sat_vec(cross_ff - fp_x, VB);
                  5'd15: qv_in[1] = sat_vec(cross_ff - fp_x, VB);
                  5'd17: qv_in[2] = sat_vec(cross_ff - fp_x, VB);
                  5'd6:          det_in = fp_d;
                  5'd7, 5'd8:    det_in = det_ff + fp_d;
                  5'd9:          un_in  = fp_d;
                  5'd10, 5'd11:  un_in  = un_ff + fp_d;
                  5'd18:         vn_in  = fp_d;
                  5'd19, 5'd20:  vn_in  = vn_ff + fp_d;
                  5'd21:         tn_in  = fp_d;
                  5'd22, 5'd23:  tn_in  = tn_ff + fp_d;
                  default: ;
               endcase
            end
            if (step_ff == MAC_LAST) state_in = S_CHECK;
         end
         S_CHECK: begin
            pass_in   = ~reject;
            t_over_in = t_over;
            if (reject) begin
               state_in = S_FINAL;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) state_in = S_FINAL;
         end
         S_FINAL: begin
            if (hit) begin
               best_t_in   = t_fin;
               best_u_in   = div_quo[0][UV_W-1:0];
               best_v_in   = div_quo[1][UV_W-1:0];
               best_idx_in = count_ff;
               found_in    = 1'b1;
            end
            this_hit_in = hit;
            if (count_ff < CNT_CAP) count_in = count_ff + 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_in.any_hit       = found_ff;
               rsp_in.this_hit      = this_hit_ff;
               rsp_in.closest_t     = best_t_ff;
               rsp_in.closest_u     = best_u_ff;
               rsp_in.closest_v     = best_v_ff;
               rsp_in.closest_index = best_idx_ff;
               rsp_valid_in         = 1'b1;
               state_in             = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   rtc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (det_abs[NUM_W-1:0]),
      .quo   (div_quo),
      .done  (div_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         org_ff       <= '0;
         dir_ff       <= '0;
         best_t_ff    <= T_MAX;
         best_u_ff    <= '0;
         best_v_ff    <= '0;
         best_idx_ff  <= '0;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         this_hit_ff  <= 1'b0;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         org_ff       <= org_in;
         dir_ff       <= dir_in;
         best_t_ff    <= best_t_in;
         best_u_ff    <= best_u_in;
         best_v_ff    <= best_v_in;
         best_idx_ff  <= best_idx_in;
         count_ff     <= count_in;
         found_ff     <= found_in;
         this_hit_ff  <= this_hit_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      e1_ff     <= e1_in;
      e2_ff     <= e2_in;
      tv_ff     <= tv_in;
      pv_ff     <= pv_in;
      qv_ff     <= qv_in;
      t_over_ff <= t_over_in;
      cross_ff  <= cross_in;
      det_ff    <= det_in;
      un_ff     <= un_in;
      vn_ff     <= vn_in;
      tn_ff     <= tn_in;
      prod_ff   <= op_a * op_b;
      rsp_ff    <= rsp_in;
   end

   `ASSERT_IMPL(a_this_hit_found, clock, reset, rsp_valid_ff && rsp_ff.this_hit, rsp_ff.any_hit)
   `ASSERT_IMPL(a_no_hit_clear, clock, reset, !found_ff, best_idx_ff == '0 && best_u_ff == '0 && best_v_ff == '0)
   `ASSERT_IMPL(a_div_done_in_div, clock, reset, div_done, state_ff == S_DIV)
   `ASSERT_NEXT(a_pop_leaves_idle, clock, reset, q_pop, state_ff != S_IDLE)
   `ASSERT_IMPL(a_count_capped, clock, reset, 1'b1, count_ff <= CNT_CAP)

endmodule

// File: rtl/ray_triangle_closest_hit.sv
// channel   | handshake            | payload
// ----------+----------------------+--------------------------------------
// request   | req_valid/req_stall  | req_data: cmd, p, q, r, far_limit
// response  | rsp_valid/rsp_stall  | rsp_data: closest-hit record
// csr       | csr_psel/penable/... | min_distance @0x0, parallel_epsilon @0x4
//
// a ray item passes the front register and the queue, then goes from idle
// straight to output; a triangle runs 24 products through the one 32x32
// multiplier, a check, the bit-serial divider, then update and output; a
// triangle rejected at the check skips the divider
// reset is synchronous and needs no clearing pass; one response per item
// a two-entry queue lets requests flow while a response is stalled until it fills
module ray_triangle_closest_hit #(
   parameter int MAX_TRIS    = rtc_pkg::DEF_MAX_TRIS,
   parameter int COORD_WIDTH = rtc_pkg::DEF_COORD_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rtc_pkg::rtc_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rtc_pkg::rtc_rsp_type rsp_data,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);
   import rtc_pkg::*;

   // configuration registers
   logic [CFG_W-1:0] min_dist_ff, min_dist_in;
   logic [CFG_W-1:0] par_eps_ff, par_eps_in;
   logic             csr_wr;

   // front end to queue to engine
   logic             q_push, q_pop;
   rtc_job_type      front_job, head_job;
   rtc_q_status_type q_status;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // word address picks the register, byte offset ignored
   always_comb begin
      min_dist_in = min_dist_ff;
      par_eps_in  = par_eps_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_MIN_DIST: min_dist_in = csr_pwdata[CFG_W-1:0];
            REG_PAR_EPS:  par_eps_in  = csr_pwdata[CFG_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_MIN_DIST: csr_prdata = {{(32-CFG_W){1'b0}}, min_dist_ff};
         REG_PAR_EPS:  csr_prdata = {{(32-CFG_W){1'b0}}, par_eps_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_dist_ff <= MIN_DIST_RESET;
         par_eps_ff  <= PAR_EPS_RESET;
      end else begin
         min_dist_ff <= min_dist_in;
         par_eps_ff  <= par_eps_in;
      end
   end

   // front end: registers each transfer, forms the edges
   rtc_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_status.full),
      .push      (q_push),
      .job       (front_job)
   );

   rtc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (front_job),
      .pop      (q_pop),
      .head     (head_job),
      .status   (q_status)
   );

   // engine: ray state, multiply sequencer, divider, closest-hit record
   rtc_back #(
      .MAX_TRIS    (MAX_TRIS),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .job              (head_job),
      .q_status         (q_status),
      .q_pop            (q_pop),
      .min_distance     (min_dist_ff),
      .parallel_epsilon (par_eps_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

endmodule
